FILE: rtl/core/wfpa_pkg.sv
// Shared types and codes for the worst-fit partition allocator.
package wfpa_pkg;

	// Fixed field widths of the item payloads
	localparam int unsigned OP_W     = 1;
	localparam int unsigned PIDX_W   = 4;
	localparam int unsigned AMOUNT_W = 16;
	localparam int unsigned PID_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_W    = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
	localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd2;

	// Reset value of the partition count register
	localparam logic [CFG_W-1:0] NUM_PARTITIONS_RST = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [PIDX_W-1:0]   partition_index;
		logic [AMOUNT_W-1:0] amount;
		logic [PID_W-1:0]    process_id;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PIDX_W-1:0]   granted_partition;
		logic [AMOUNT_W-1:0] leftover;
		logic [PID_W-1:0]    owner_id;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;    // latch the input item, restart the scan
		logic load_wr;    // write the size table and free the entry
		logic scan_step;  // read the next table entry
		logic finish;     // build the result and update the used mark
	} wfpa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_end;   // every partition in use has been read
		logic out_busy;   // result register full and not taken this cycle
	} wfpa_sts_t;

endpackage

FILE: rtl/core/wfpa_datapath.sv
// Datapath: size table, used marks, scan comparator, best tracker and result register.
module wfpa_datapath #(
	parameter int unsigned MAX_PARTITIONS = 16,
	parameter int unsigned SIZE_BITS      = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wfpa_pkg::in_item_t             in_data,
	input  logic                           cfg_we,
	input  logic [wfpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  wfpa_pkg::wfpa_cmd_t            cmd,
	output wfpa_pkg::wfpa_sts_t            sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output wfpa_pkg::out_item_t            out_data
);

	localparam int unsigned IDX_W   = $clog2(MAX_PARTITIONS);
	localparam int unsigned CNT_W   = $clog2(MAX_PARTITIONS + 1);
	localparam int unsigned LIM_W   = (CNT_W > wfpa_pkg::CFG_W) ? CNT_W : wfpa_pkg::CFG_W;
	localparam int unsigned IXE_W   = (IDX_W > wfpa_pkg::PIDX_W) ? IDX_W : wfpa_pkg::PIDX_W;
	localparam int unsigned SZE_W   = (SIZE_BITS > wfpa_pkg::AMOUNT_W) ?
		SIZE_BITS : wfpa_pkg::AMOUNT_W;
	localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_PARTITIONS);

	// Configuration
	logic [wfpa_pkg::CFG_W-1:0] num_partitions_q;
	logic [LIM_W-1:0]           cfg_ext;
	logic [LIM_W-1:0]           limit;

	// Captured item
	logic [wfpa_pkg::OP_W-1:0]   op_q;
	logic [wfpa_pkg::PIDX_W-1:0] pidx_q;
	logic [SIZE_BITS-1:0]        amt_q;
	logic [wfpa_pkg::PID_W-1:0]  pid_q;
	logic [SZE_W-1:0]            amt_ext;

	// Table
	logic [SIZE_BITS-1:0]  size_mem [MAX_PARTITIONS];
	logic                  used_q [MAX_PARTITIONS];
	logic [IXE_W-1:0]      pidx_ext;
	logic [IDX_W-1:0]      load_addr;
	logic                  load_in_range;

	// Scan
	logic [LIM_W-1:0]      scan_q;
	logic [IDX_W-1:0]      scan_addr;
	logic [SIZE_BITS-1:0]  rd_size_s1;
	logic                  rd_used_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  rd_vld_s1;
	logic                  fits;
	logic                  better;

	// Best candidate
	logic                  found_q;
	logic [IDX_W-1:0]      best_q;
	logic [SIZE_BITS-1:0]  best_size_q;
	logic [SIZE_BITS-1:0]  diff;
	logic [SZE_W-1:0]      diff_ext;
	logic [IXE_W-1:0]      best_ext;

	// Result register
	logic                  out_valid_q;
	wfpa_pkg::out_item_t   out_d;
	wfpa_pkg::out_item_t   out_q;

	// Hold the partition count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_partitions_q <= wfpa_pkg::NUM_PARTITIONS_RST;
		end else if (cfg_we) begin
			num_partitions_q <= cfg_wdata;
		end
	end

	// Clamp the count to the table depth
	assign cfg_ext = LIM_W'(num_partitions_q);
	assign limit   = (cfg_ext > MAX_L) ? MAX_L : cfg_ext;

	// Latch the accepted item
	assign amt_ext = SZE_W'(in_data.amount);
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_data.operation;
			pidx_q <= in_data.partition_index;
			amt_q  <= amt_ext[SIZE_BITS-1:0];
			pid_q  <= in_data.process_id;
		end
	end

	// Decode the load address
	assign pidx_ext      = IXE_W'(pidx_q);
	assign load_addr     = pidx_ext[IDX_W-1:0];
	assign load_in_range = (LIM_W'(pidx_q) < MAX_L);

	// Write sizes on load; read one entry per scan step
	assign scan_addr = scan_q[IDX_W-1:0];
	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_in_range) begin
			size_mem[load_addr] <= amt_q;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_size_s1 <= size_mem[scan_addr];
			rd_used_s1 <= used_q[scan_addr];
			rd_idx_s1  <= scan_addr;
		end
	end

	// Free on load, mark used on grant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PARTITIONS; i++) begin
				used_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.load_wr && load_in_range) begin
				used_q[load_addr] <= 1'b0;
			end
			if (cmd.finish && (op_q == wfpa_pkg::OP_REQUEST) && found_q) begin
				used_q[best_q] <= 1'b1;
			end
		end
	end

	// Advance the scan counter and track the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.capture) begin
				scan_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	assign sts.scan_end = (scan_q >= limit);

	// Compare the read entry against the request and the best so far
	assign fits   = rd_vld_s1 && !rd_used_s1 && (rd_size_s1 >= amt_q);
	assign better = !found_q || (rd_size_s1 > best_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			found_q <= 1'b0;
		end else if (fits) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fits && better) begin
			best_q      <= rd_idx_s1;
			best_size_q <= rd_size_s1;
		end
	end

	// Form the leftover and the granted index at field width
	assign diff     = best_size_q - amt_q;
	assign diff_ext = SZE_W'(diff);
	assign best_ext = IXE_W'(best_q);

	// Build the result item
	always_comb begin
		out_d = '0;
		if (op_q == wfpa_pkg::OP_REQUEST) begin
			out_d.owner_id = pid_q;
			if (found_q) begin
				out_d.status            = wfpa_pkg::ST_GRANTED;
				out_d.granted_partition = best_ext[wfpa_pkg::PIDX_W-1:0];
				out_d.leftover          = diff_ext[wfpa_pkg::AMOUNT_W-1:0];
			end else begin
				out_d.status = wfpa_pkg::ST_NO_FIT;
			end
		end else begin
			out_d.status = wfpa_pkg::ST_LOADED;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= out_d;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// The best candidate always holds the request
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_size_q >= amt_q))
		else $error("best candidate smaller than request");

	// A grant marks its partition used
	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (op_q == wfpa_pkg::OP_REQUEST) && found_q)
		|=> used_q[$past(best_q)])
		else $error("granted partition not marked used");

	// A load frees its partition
	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_wr && load_in_range) |=> !used_q[$past(load_addr)])
		else $error("loaded partition still marked used");

	// The scan never reads past the partitions in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (scan_q < limit))
		else $error("scan beyond partition count");

endmodule

FILE: rtl/core/wfpa_ctrl.sv
// Controller: sequences capture, table load, scan and result hand-off.
module wfpa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [wfpa_pkg::OP_W-1:0]     in_op,
	output logic                          in_ready,
	input  wfpa_pkg::wfpa_sts_t           sts,
	output wfpa_pkg::wfpa_cmd_t           cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOAD   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = (in_op == wfpa_pkg::OP_LOAD) ? S_LOAD : S_SCAN;
				end
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Only one command is active in any cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one command at once");

	// A finished item always returns to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE))
		else $error("controller did not return to idle");

	// A scan always ends in the finish state
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && sts.scan_end) |=> (state_q == S_FINISH))
		else $error("scan did not hand over to finish");

endmodule

FILE: rtl/core/worst_fit_partition_allocator.sv
// Top level of the worst-fit partition allocator.
// Keeps MAX_PARTITIONS partition sizes and used marks. A load item writes one size, frees the
// partition and answers "loaded". A request item scans count entries, where count is the
// partition count register clamped to MAX_PARTITIONS: the size table has one read port and the
// scan reads one entry a cycle into a single comparator, then the best candidate settles and the
// finish state writes the result and the used mark once the result register is free. The
// largest free partition at least as large as the request is granted, the lowest index on ties.
// A new item is taken once the previous one has reached the result register, even while that
// result still waits to be taken. Sizes of partitions never loaded are undefined. The partition
// count must be written only while the block is idle; the block itself does not enforce this.
module worst_fit_partition_allocator #(
	parameter int unsigned MAX_PARTITIONS = 16,
	parameter int unsigned SIZE_BITS      = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  wfpa_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output wfpa_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [wfpa_pkg::CFG_W-1:0] cfg_wdata
);

	wfpa_pkg::wfpa_cmd_t cmd;
	wfpa_pkg::wfpa_sts_t sts;

	wfpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wfpa_datapath #(
		.MAX_PARTITIONS (MAX_PARTITIONS),
		.SIZE_BITS      (SIZE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
